/* sv/trinomial_tree_option_pricer_assert.svh */
// Assertion macros for the trinomial tree option pricer checker.
`ifndef TRINOMIAL_TREE_OPTION_PRICER_ASSERT_SVH
`define TRINOMIAL_TREE_OPTION_PRICER_ASSERT_SVH

// Implication into the next cycle, off while reset is held.
`define TTO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tto assertion failed");

// Implication into the next cycle, checked during reset as well.
`define TTO_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("tto assertion failed");

`endif

/* sv/tto_pkg.sv */
// ----------------------------------------------------------------------------
// tto_pkg
// Shared constants, types and payoff function for the trinomial tree pricer.
// ----------------------------------------------------------------------------
`default_nettype none

package tto_pkg;

    // Lattice size
    localparam int MAX_STEPS = 256;
    localparam int NODE_CNT  = 2 * MAX_STEPS + 1;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int ADDR_W    = $clog2(NODE_CNT + 1);

    // Field widths
    localparam int VAL_W     = 32;
    localparam int CFG_STEPS_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 65;   // signed 33 x 32 product
    localparam int SUM_W     = 67;   // three products
    localparam int FRAC_W    = 30;   // Q2.30 coefficient fraction

    typedef logic [VAL_W-1:0] t_val;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEPS    = 3'd0,
        CFG_UP       = 3'd1,
        CFG_DOWN     = 3'd2,
        CFG_PROB_UP  = 3'd3,
        CFG_PROB_MID = 3'd4,
        CFG_PROB_DN  = 3'd5,
        CFG_DISCOUNT = 3'd6
    } t_cfg_idx;

    // Control into the combine row
    typedef struct packed {
        logic shift;    // a node value enters the row
        logic win_v;    // the row holds a full three-node window
    } t_comb_ctl;

    // Status out of the combine row
    typedef struct packed {
        logic valid;    // result ready to write back
        logic busy;     // products or result still in flight
        logic sat;      // result was clipped
        t_val val;
    } t_comb_res;

    typedef struct packed {
        t_val val;
        logic sat;
    } t_pay;

    // Terminal payoff; a stuck (saturated) stock price pins a call and zeroes a put
    function automatic t_pay payoff(t_val s, logic s_sat, logic put, t_val k);
        t_pay r;
        r.sat = 1'b0;
        if (put) begin
            r.val = (s_sat || k <= s) ? '0 : t_val'(k - s);
        end else if (s_sat) begin
            r.val = '1;
            r.sat = 1'b1;
        end else begin
            r.val = (s > k) ? t_val'(s - k) : '0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/trinomial_tree_option_pricer.sv */
// ----------------------------------------------------------------------------
// trinomial_tree_option_pricer
// European option pricer on a recombining trinomial lattice.
//  - Coefficients are to be written on the i_cfg_* port only while the block
//    is idle; the user is bound to this, the block itself does not enforce it.
//  - Input item on s_axis: tdata = {strike, spot}, tuser = put flag.
//  - Result item on m_axis: tdata = price, tuser = saturated flag.
//  - One item is in work at a time; s_axis_tready is high only when idle.
//  - Per item, the terminal row is built first (one stock multiply per outer
//    node), then N induction rounds run, round i streaming 2*(N-i)+1 nodes
//    from the node RAM through the three-cell combine row at one node per
//    cycle with fill and drain, then the discounted root is formed in
//    S_ROOT_RD, S_ROOT_MUL and S_ROOT_FIN.
//  - The finished result sits in an output register; the next item may be
//    accepted while it waits. If the receiver stalls, the following result
//    holds in the last step until the output register frees.
//  - Reset clears control and restores register defaults; the node RAM is not
//    cleared, every entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module trinomial_tree_option_pricer import tto_pkg::*; (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // configuration write port
    input  wire                       i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]      i_cfg_addr,
    input  wire  [VAL_W-1:0]          i_cfg_data,
    // input items
    input  wire                       s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire  [2*VAL_W-1:0]        s_axis_tdata,   // [31:0] spot, [63:32] strike
    input  wire                       s_axis_tuser,   // [0] req_type
    // result items
    output logic                      m_axis_tvalid,
    input  wire                       m_axis_tready,
    output logic [VAL_W-1:0]          m_axis_tdata,   // [31:0] price
    output logic                      m_axis_tuser    // [0] saturated
);

    typedef enum logic [2:0] {
        S_IDLE, S_CENTER, S_MUL, S_WR, S_ROUND, S_ROOT_RD, S_ROOT_MUL, S_ROOT_FIN
    } t_state;

    t_state                r_state;
    logic [CFG_STEPS_W-1:0] r_steps;
    t_val                  r_up, r_dn, r_pu, r_pm, r_pd, r_disc;
    logic                  r_put;
    t_val                  r_spot, r_strike, r_s;
    logic                  r_ssat, r_up_side, r_sat;
    logic [STEP_W-1:0]     r_n, r_cnt, r_rounds;
    logic [ADDR_W-1:0]     r_j, r_span, r_rd_idx, r_wr_idx;
    logic [2*VAL_W-1:0]    r_prod;
    logic                  r_rd_on, r_rd_v, r_win_v;
    logic [1:0]            r_seen;
    logic                  r_out_v, r_out_sat;
    t_val                  r_out;

    // node RAM
    t_val                  mem [NODE_CNT];
    t_val                  r_rdata;

    logic                  w_we, w_re;
    logic [ADDR_W-1:0]     w_waddr, w_raddr;
    t_val                  w_wdata;
    logic [STEP_W-1:0]     w_n;
    logic [VAL_W+1:0]      w_p;
    t_val                  w_s_new;
    logic                  w_ssat_new;
    t_pay                  w_pay_c, w_pay;
    t_comb_ctl             w_ctl;
    t_comb_res             w_res;
    logic                  w_out_free, w_round_end;

    // step count clamp: zero acts as one, above the maximum as the maximum
    always_comb begin
        if (r_steps == '0) begin
            w_n = STEP_W'(1);
        end else if (32'(r_steps) > 32'(MAX_STEPS)) begin
            w_n = STEP_W'(MAX_STEPS);
        end else begin
            w_n = STEP_W'(r_steps);
        end
    end

    // stock walk: scaled price, stuck once it overflows
    assign w_p = r_prod[2*VAL_W-1:FRAC_W];
    always_comb begin
        if (r_ssat || w_p[VAL_W+1:VAL_W] != '0) begin
            w_s_new    = '1;
            w_ssat_new = 1'b1;
        end else begin
            w_s_new    = w_p[VAL_W-1:0];
            w_ssat_new = 1'b0;
        end
    end

    assign w_pay_c = payoff(r_spot, 1'b0, r_put, r_strike);
    assign w_pay   = payoff(w_s_new, w_ssat_new, r_put, r_strike);

    // RAM port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wr_idx;
        w_wdata = w_res.val;
        case (r_state)
            S_CENTER: begin
                w_we    = 1'b1;
                w_waddr = ADDR_W'(r_n);
                w_wdata = w_pay_c.val;
            end
            S_WR: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = w_pay.val;
            end
            S_ROUND: begin
                w_we    = w_res.valid;
            end
            default: begin
                w_we    = 1'b0;
            end
        endcase
    end

    assign w_re    = (r_state == S_ROUND && r_rd_on) || (r_state == S_ROOT_RD);
    assign w_raddr = (r_state == S_ROUND) ? r_rd_idx : '0;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // combine row
    assign w_ctl.shift = r_rd_v;
    assign w_ctl.win_v = r_win_v;

    tto_combine u_combine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_din      (r_rdata),
        .i_prob_up  (r_pu),
        .i_prob_mid (r_pm),
        .i_prob_dn  (r_pd),
        .o_res      (w_res)
    );

    assign w_out_free  = !r_out_v || m_axis_tready;
    assign w_round_end = !r_rd_on && !r_rd_v && !r_win_v && !w_res.busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= CFG_STEPS_W'(1);
            r_up    <= 32'h4000_0000;
            r_dn    <= 32'h4000_0000;
            r_pu    <= '0;
            r_pm    <= 32'h4000_0000;
            r_pd    <= '0;
            r_disc  <= 32'h4000_0000;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_STEPS:    r_steps <= i_cfg_data[CFG_STEPS_W-1:0];
                CFG_UP:       r_up    <= i_cfg_data;
                CFG_DOWN:     r_dn    <= i_cfg_data;
                CFG_PROB_UP:  r_pu    <= i_cfg_data;
                CFG_PROB_MID: r_pm    <= i_cfg_data;
                CFG_PROB_DN:  r_pd    <= i_cfg_data;
                CFG_DISCOUNT: r_disc  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd_on <= 1'b0;
            r_rd_v  <= 1'b0;
            r_win_v <= 1'b0;
            r_seen  <= '0;
            r_out_v <= 1'b0;
        end else begin
            // read pipeline into the row
            r_rd_v  <= (r_state == S_ROUND) && r_rd_on;
            r_win_v <= r_rd_v && (r_seen == 2'd2);
            if (r_rd_v && r_seen != 2'd2) begin
                r_seen <= r_seen + 2'd1;
            end
            // result register: load on the last step, clear once taken
            if (r_state == S_ROOT_FIN && w_out_free) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_put    <= s_axis_tuser;
                        r_spot   <= s_axis_tdata[VAL_W-1:0];
                        r_strike <= s_axis_tdata[2*VAL_W-1:VAL_W];
                        r_n      <= w_n;
                        r_state  <= S_CENTER;
                    end
                end
                S_CENTER: begin
                    r_sat     <= w_pay_c.sat;
                    r_s       <= r_spot;
                    r_ssat    <= 1'b0;
                    r_up_side <= 1'b1;
                    r_j       <= ADDR_W'(r_n) + ADDR_W'(1);
                    r_cnt     <= r_n;
                    r_state   <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= (2*VAL_W)'(r_s) * (2*VAL_W)'(r_up_side ? r_up : r_dn);
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_sat <= r_sat | w_pay.sat;
                    // down side restarts from the spot price
                    if (r_cnt == STEP_W'(1) && r_up_side) begin
                        r_s    <= r_spot;
                        r_ssat <= 1'b0;
                    end else begin
                        r_s    <= w_s_new;
                        r_ssat <= w_ssat_new;
                    end
                    if (r_cnt == STEP_W'(1)) begin
                        if (r_up_side) begin
                            r_up_side <= 1'b0;
                            r_j       <= ADDR_W'(r_n) - ADDR_W'(1);
                            r_cnt     <= r_n;
                            r_state   <= S_MUL;
                        end else begin
                            r_span   <= ADDR_W'({r_n, 1'b1});
                            r_rounds <= r_n;
                            r_rd_on  <= 1'b1;
                            r_rd_idx <= '0;
                            r_wr_idx <= '0;
                            r_seen   <= '0;
                            r_state  <= S_ROUND;
                        end
                    end else begin
                        r_cnt   <= r_cnt - STEP_W'(1);
                        r_j     <= r_up_side ? r_j + ADDR_W'(1) : r_j - ADDR_W'(1);
                        r_state <= S_MUL;
                    end
                end
                S_ROUND: begin
                    if (r_rd_on) begin
                        r_rd_idx <= r_rd_idx + ADDR_W'(1);
                        if (r_rd_idx == r_span - ADDR_W'(1)) begin
                            r_rd_on <= 1'b0;
                        end
                    end
                    if (w_res.valid) begin
                        r_wr_idx <= r_wr_idx + ADDR_W'(1);
                        r_sat    <= r_sat | w_res.sat;
                    end
                    // next round starts once the row has drained
                    if (w_round_end) begin
                        if (r_rounds == STEP_W'(1)) begin
                            r_state <= S_ROOT_RD;
                        end else begin
                            r_rounds <= r_rounds - STEP_W'(1);
                            r_span   <= r_span - ADDR_W'(2);
                            r_rd_on  <= 1'b1;
                            r_rd_idx <= '0;
                            r_wr_idx <= '0;
                            r_seen   <= '0;
                        end
                    end
                end
                S_ROOT_RD: begin
                    r_state <= S_ROOT_MUL;
                end
                S_ROOT_MUL: begin
                    r_prod  <= (2*VAL_W)'(r_rdata) * (2*VAL_W)'(r_disc);
                    r_state <= S_ROOT_FIN;
                end
                S_ROOT_FIN: begin
                    if (w_out_free) begin
                        if (w_p[VAL_W+1:VAL_W] != '0) begin
                            r_out     <= '1;
                            r_out_sat <= 1'b1;
                        end else begin
                            r_out     <= w_p[VAL_W-1:0];
                            r_out_sat <= r_sat;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_out_sat;

endmodule

`default_nettype wire

/* sv/tto_cell.sv */
// ----------------------------------------------------------------------------
// tto_cell
// One window cell: holds a node value, passes it on, registers coef * value.
// ----------------------------------------------------------------------------
`default_nettype none

module tto_cell import tto_pkg::*; (
    input  wire                      i_clk,
    input  wire                      i_shift,
    input  wire  t_val               i_din,
    input  wire  logic [VAL_W-1:0]   i_coef,
    output t_val                     o_val,
    output logic signed [PROD_W-1:0] o_prod
);

    t_val                     r_val;
    logic signed [PROD_W-1:0] r_prod;

    // value moves one cell down the row on each shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_din;
        end
        r_prod <= $signed({1'b0, r_val}) * $signed(i_coef);
    end

    assign o_val  = r_val;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* sv/tto_combine.sv */
// ----------------------------------------------------------------------------
// tto_combine
// Row of three cells (down, mid, up) and the floor/saturate sum stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tto_combine import tto_pkg::*; (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire  t_comb_ctl i_ctl,
    input  wire  t_val      i_din,
    input  wire  t_val      i_prob_up,
    input  wire  t_val      i_prob_mid,
    input  wire  t_val      i_prob_dn,
    output t_comb_res       o_res
);

    t_val                     w_val_u, w_val_m, w_val_d;
    logic signed [PROD_W-1:0] w_prod_u, w_prod_m, w_prod_d;
    logic signed [SUM_W-1:0]  w_sum;
    logic [SUM_W-FRAC_W-1:0]  w_q;
    logic                     r_prod_v, r_res_v, r_res_sat;
    t_val                     r_res;

    // newest value enters at the up cell, oldest sits in the down cell
    tto_cell u_cell_up (
        .i_clk(i_clk), .i_shift(i_ctl.shift), .i_din(i_din),
        .i_coef(i_prob_up), .o_val(w_val_u), .o_prod(w_prod_u)
    );
    tto_cell u_cell_mid (
        .i_clk(i_clk), .i_shift(i_ctl.shift), .i_din(w_val_u),
        .i_coef(i_prob_mid), .o_val(w_val_m), .o_prod(w_prod_m)
    );
    tto_cell u_cell_dn (
        .i_clk(i_clk), .i_shift(i_ctl.shift), .i_din(w_val_m),
        .i_coef(i_prob_dn), .o_val(w_val_d), .o_prod(w_prod_d)
    );

    // exact sum, floor by dropping the fraction bits
    assign w_sum = SUM_W'(w_prod_u) + SUM_W'(w_prod_m) + SUM_W'(w_prod_d);
    assign w_q   = w_sum[SUM_W-1:FRAC_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
            r_res_v  <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.win_v;
            r_res_v  <= r_prod_v;
        end
        // clip to the unsigned Q16.16 range
        if (w_q[SUM_W-FRAC_W-1]) begin
            r_res     <= '0;
            r_res_sat <= 1'b1;
        end else if (w_q[SUM_W-FRAC_W-2:VAL_W] != '0) begin
            r_res     <= '1;
            r_res_sat <= 1'b1;
        end else begin
            r_res     <= w_q[VAL_W-1:0];
            r_res_sat <= 1'b0;
        end
    end

    assign o_res.valid = r_res_v;
    assign o_res.busy  = r_prod_v | r_res_v;
    assign o_res.sat   = r_res_sat;
    assign o_res.val   = r_res;

    // window values are consumed through the cell products
    logic w_unused;
    assign w_unused = ^w_val_d;

endmodule

`default_nettype wire

/* sv/tto_checker.sv */
// ----------------------------------------------------------------------------
// tto_checker
// Port-level checks on the pricer, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trinomial_tree_option_pricer_assert.svh"

module tto_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire        m_axis_tuser
);

    // no result survives reset
    `TTO_ASSERT_NEXT_ALWAYS(a_rst_clears_out, !i_rst_n, !m_axis_tvalid)

    // stalled result holds
    `TTO_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // an accepted item keeps the input closed while it is priced
    `TTO_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a new result never appears right after an item is taken
    `TTO_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready,
        !$rose(m_axis_tvalid))

endmodule

bind trinomial_tree_option_pricer tto_checker u_tto_checker (.*);

`default_nettype wire

/* tb/trinomial_tree_option_pricer_tb.sv */
// ----------------------------------------------------------------------------
// trinomial_tree_option_pricer_tb
// Self-checking bench for the trinomial lattice option pricer. Each accepted
// item is priced by a local bit-exact lattice model, and every returned price
// and saturation flag is compared in order. Covers register defaults, field
// extremes, stock, induction and discount saturation, step count clamping and
// random coefficient sets, with random idling and a long receiver stall.
// ----------------------------------------------------------------------------
`default_nettype none

module trinomial_tree_option_pricer_tb;
    import tto_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic REQ_CALL = 1'b0;
    localparam logic REQ_PUT  = 1'b1;

    typedef struct {
        logic [31:0] price;
        logic        sat;
    } t_quote;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;    // [31:0] spot, [63:32] strike
    logic        s_axis_tuser;    // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [31:0] price
    logic        m_axis_tuser;    // [0] saturated

    trinomial_tree_option_pricer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the coefficient registers
    logic [8:0]  lat_steps;
    logic [31:0] lat_up, lat_down, lat_pu, lat_pm, lat_pd, lat_disc;
    logic [31:0] lattice [0:NODE_CNT-1];

    t_quote quote_q[$];
    int     err_cnt;
    int     items_sent;
    int     quotes_seen;
    int     rx_hold;       // requested long receiver stall, in cycles
    bit     no_idle;       // stretch with no gaps on either side

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // Bit-exact lattice price for the current coefficient set
    function automatic t_quote price_option(logic put, logic [31:0] spot,
                                            logic [31:0] strike);
        t_quote r;
        int n;
        logic [31:0] s;
        logic stuck;
        logic [63:0] p;
        logic signed [69:0] acc;
        logic signed [69:0] q;
        r.sat = 1'b0;
        n = (lat_steps == 0) ? 1 : (lat_steps > MAX_STEPS) ? MAX_STEPS : lat_steps;
        // terminal row: center, then outward on each side
        for (int side = 0; side < 3; side++) begin
            s = spot;
            stuck = 1'b0;
            for (int j = 0; j <= n; j++) begin
                if (side == 0 && j > 0) break;
                if (side != 0 && j == 0) continue;
                if (side != 0) begin
                    p = ({32'b0, s} * {32'b0, (side == 1) ? lat_up : lat_down}) >> 30;
                    if (stuck || p > {32'b0, ALL_ONES}) begin
                        stuck = 1'b1;
                        s = ALL_ONES;
                    end else begin
                        s = p[31:0];
                    end
                end
                if (put)
                    lattice[n + ((side == 2) ? -j : j)] = (stuck || strike <= s) ? '0 : strike - s;
                else if (stuck) begin
                    lattice[n + ((side == 2) ? -j : j)] = ALL_ONES;
                    r.sat = 1'b1;
                end else
                    lattice[n + ((side == 2) ? -j : j)] = (s > strike) ? s - strike : '0;
            end
        end
        // backward induction, floor of the exact three-term sum
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 2 * (n - i) - 1; k++) begin
                acc = $signed(lat_pu) * $signed({1'b0, lattice[k+2]})
                    + $signed(lat_pm) * $signed({1'b0, lattice[k+1]})
                    + $signed(lat_pd) * $signed({1'b0, lattice[k]});
                q = acc >>> 30;
                if (q < 0) begin
                    lattice[k] = '0;
                    r.sat = 1'b1;
                end else if (q > $signed(70'h0_FFFF_FFFF)) begin
                    lattice[k] = ALL_ONES;
                    r.sat = 1'b1;
                end else begin
                    lattice[k] = q[31:0];
                end
            end
        end
        p = ({32'b0, lattice[0]} * {32'b0, lat_disc}) >> 30;
        if (p > {32'b0, ALL_ONES}) begin
            r.price = ALL_ONES;
            r.sat = 1'b1;
        end else begin
            r.price = p[31:0];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // Write one register; caller lowers the enable after the batch
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_STEPS:    lat_steps = val[8:0];
            CFG_UP:       lat_up    = val;
            CFG_DOWN:     lat_down  = val;
            CFG_PROB_UP:  lat_pu    = val;
            CFG_PROB_MID: lat_pm    = val;
            CFG_PROB_DN:  lat_pd    = val;
            CFG_DISCOUNT: lat_disc  = val;
            default: ;
        endcase
    endtask

    task automatic set_lattice(logic [31:0] steps, logic [31:0] up, logic [31:0] dn,
                               logic [31:0] pu, logic [31:0] pm, logic [31:0] pd,
                               logic [31:0] disc);
        cfg_write(CFG_STEPS, steps);
        cfg_write(CFG_UP, up);
        cfg_write(CFG_DOWN, dn);
        cfg_write(CFG_PROB_UP, pu);
        cfg_write(CFG_PROB_MID, pm);
        cfg_write(CFG_PROB_DN, pd);
        cfg_write(CFG_DISCOUNT, disc);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one item and hold it until accepted; tvalid stays high for a back-to-back item
    task automatic send_quote_req(logic put, logic [31:0] spot, logic [31:0] strike);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= put;
        s_axis_tdata  <= {strike, spot};
        do @(posedge i_clk); while (!s_axis_tready);
        quote_q.push_back(price_option(put, spot, strike));
        items_sent++;
    endtask

    // Drop valid, wait for all quotes, then settle before a register change
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (quote_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Result checker with random stalls
    initial begin
        t_quote exp_q;
        int stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                quotes_seen++;
                if (quote_q.size() == 0) begin
                    $error("unexpected result: price %h sat %b", m_axis_tdata, m_axis_tuser);
                    err_cnt++;
                end else begin
                    exp_q = quote_q.pop_front();
                    if (m_axis_tdata !== exp_q.price) begin
                        $error("price: expected %h, got %h", exp_q.price, m_axis_tdata);
                        err_cnt++;
                    end
                    if (m_axis_tuser !== exp_q.sat) begin
                        $error("saturated: expected %b, got %b", exp_q.sat, m_axis_tuser);
                        err_cnt++;
                    end
                end
            end
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
            end else if (stall == 0 && !no_idle) begin
                stall = $urandom_range(0, 99) < 85 ? 0 :
                        ($urandom_range(0, 9) == 0 ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 3));
            end
            if (stall > 0) stall--;
            m_axis_tready <= (stall == 0);
        end
    end

    // Register defaults: one step, identity coefficients, so price is the payoff
    task automatic test_defaults();
        send_quote_req(REQ_CALL, 32'h0005_0000, 32'h0003_0000);
        send_quote_req(REQ_PUT,  32'h0005_0000, 32'h0003_0000);
        send_quote_req(REQ_PUT,  32'h0000_0000, ALL_ONES);
        send_quote_req(REQ_CALL, ALL_ONES, 32'h0000_0000);
        send_quote_req(REQ_CALL, 32'h0000_0000, ALL_ONES);
        drain();
    endtask

    // Writes to the unused index are dropped
    task automatic test_unused_index();
        cfg_write(CFG_UNUSED, 32'h0000_0003);
        i_cfg_we <= 1'b0;
        send_quote_req(REQ_CALL, 32'h0010_0000, 32'h0008_0000);
        drain();
    endtask

    // Stock price overflow on the up side, induction clipping both ways, discount overflow
    task automatic test_saturation();
        set_lattice(4, ALL_ONES, 32'h2000_0000, 32'h1555_5555, 32'h1555_5555,
                    32'h1555_5556, Q30_ONE);
        send_quote_req(REQ_CALL, 32'h8000_0000, 32'h0001_0000);
        send_quote_req(REQ_PUT,  32'h8000_0000, ALL_ONES);
        drain();
        set_lattice(2, 32'h4800_0000, 32'h3900_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, Q30_ONE);
        send_quote_req(REQ_CALL, 32'hF000_0000, 32'h0000_0001);
        drain();
        set_lattice(3, 32'h4800_0000, 32'h3900_0000, 32'h8000_0000, 32'h4000_0000,
                    32'h1000_0000, Q30_ONE);
        send_quote_req(REQ_CALL, 32'h0100_0000, 32'h0080_0000);
        send_quote_req(REQ_PUT,  32'h0100_0000, 32'h0180_0000);
        drain();
        set_lattice(1, Q30_ONE, Q30_ONE, 32'h0, Q30_ONE, 32'h0, ALL_ONES);
        send_quote_req(REQ_CALL, ALL_ONES, 32'h0);
        send_quote_req(REQ_PUT, 32'h0, 32'h1000_0000);
        drain();
        set_lattice(1, Q30_ONE, Q30_ONE, 32'h0, Q30_ONE, 32'h0, 32'h0);
        send_quote_req(REQ_CALL, ALL_ONES, 32'h0);
        drain();
    endtask

    // Step count zero acts as one; above the maximum clamps to the maximum
    task automatic test_step_clamp();
        set_lattice(0, 32'h4200_0000, 32'h3E10_0000, 32'h1555_5555, 32'h1555_5555,
                    32'h1555_5556, 32'h3F00_0000);
        send_quote_req(REQ_CALL, 32'h0064_0000, 32'h0060_0000);
        drain();
        set_lattice(9'h1FF, 32'h4010_0000, 32'h3FF0_0400, 32'h1555_5555, 32'h1555_5555,
                    32'h1555_5556, 32'h3F00_0000);
        send_quote_req(REQ_PUT, 32'h0064_0000, 32'h0068_0000);
        drain();
        cfg_write(CFG_STEPS, MAX_STEPS);
        i_cfg_we <= 1'b0;
        send_quote_req(REQ_CALL, 32'h0064_0000, 32'h0060_0000);
        drain();
    endtask

    // Random coefficient sets, each followed by a burst of random items
    task automatic test_random();
        logic [31:0] pu, pd, spot, strike;
        for (int set = 0; set < 8; set++) begin
            pu = $urandom_range(32'h0800_0000, 32'h1800_0000);
            pd = $urandom_range(32'h0800_0000, 32'h1800_0000);
            if (set == 5)
                set_lattice($urandom_range(1, 6), $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom);
            else
                set_lattice($urandom_range(1, 12), Q30_ONE + $urandom_range(0, 32'h0400_0000),
                            Q30_ONE - $urandom_range(0, 32'h0400_0000), pu,
                            Q30_ONE - pu - pd, pd, $urandom_range(32'h3800_0000, Q30_ONE));
            no_idle = (set == 3);
            for (int i = 0; i < 11; i++) begin
                spot = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 32'h00FF_FFFF);
                strike = ($urandom_range(0, 2) == 0) ? $urandom
                                                     : spot + $urandom_range(0, 32'h0020_0000)
                                                       - 32'h0010_0000;
                send_quote_req($urandom_range(0, 1), spot, strike);
            end
            drain();
            no_idle = 1'b0;
        end
    endtask

    // Long receiver stall while items keep coming, so the input stalls
    task automatic test_backpressure();
        set_lattice(2, 32'h4100_0000, 32'h3F00_0000, 32'h1555_5555, 32'h1555_5555,
                    32'h1555_5556, 32'h3FF0_0000);
        rx_hold = 600;
        for (int i = 0; i < 8; i++)
            send_quote_req($urandom_range(0, 1), $urandom_range(1, 32'h00FF_FFFF),
                           $urandom_range(1, 32'h00FF_FFFF));
        drain();
    endtask

    initial begin
        err_cnt = 0;
        items_sent = 0;
        quotes_seen = 0;
        rx_hold = 0;
        no_idle = 1'b0;
        lat_steps = 1;
        lat_up = Q30_ONE;
        lat_down = Q30_ONE;
        lat_pu = '0;
        lat_pm = Q30_ONE;
        lat_pd = '0;
        lat_disc = Q30_ONE;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_unused_index();
        test_saturation();
        test_step_clamp();
        test_random();
        test_backpressure();

        repeat (50) @(posedge i_clk);
        $display("Priced %0d options and checked %0d quotes: defaults, field extremes,",
                 items_sent, quotes_seen);
        $display("saturation paths, step clamping, random lattices and a long output stall.");
        if (err_cnt == 0 && quote_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+sv
sv/tto_pkg.sv
sv/tto_cell.sv
sv/tto_combine.sv
sv/trinomial_tree_option_pricer.sv
sv/tto_checker.sv
tb/trinomial_tree_option_pricer_tb.sv
